// ===== hdl/mlpg_pkg.sv =====
// Shared types, codes and the sizing function of the midpoint line pixel generator.
package mlpg_pkg;

   localparam int ORIGIN_BITS = 12;
   localparam int SCREEN_BITS = 14;
   localparam int COLOUR_BITS = 4;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_X = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_Y = 1'b1;

   typedef enum logic [1:0] {
      OCT_SHALLOW_RISE = 2'd0,
      OCT_STEEP_RISE = 2'd1,
      OCT_SHALLOW_FALL = 2'd2,
      OCT_STEEP_FALL = 2'd3
   } octant_type;

   // Width of one classified command word in the queue.
   function automatic int cmd_width(input int coord_bits);
      return 6 * coord_bits + 17;
   endfunction

endpackage

// ===== hdl/mlpg_req_if.sv =====
// Request channel: line commands with endpoints and pen colour.
interface mlpg_req_if #(parameter int COORD_BITS = 12);
   logic valid;
   logic ready;
   logic command;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [3:0] pen_colour;

   modport source (output valid, command, start_x, start_y, end_x, end_y, pen_colour,
                   input ready);
   modport sink (input valid, command, start_x, start_y, end_x, end_y, pen_colour,
                 output ready);
endinterface

// ===== hdl/mlpg_rsp_if.sv =====
// Response channel: one screen pixel per transaction.
interface mlpg_rsp_if;
   logic valid;
   logic ready;
   logic signed [13:0] pixel_x;
   logic signed [13:0] pixel_y;
   logic [3:0] pixel_colour;
   logic pixel_valid;
   logic last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_colour, pixel_valid, last_pixel,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_colour, pixel_valid, last_pixel,
                 output ready);
endinterface

// ===== hdl/mlpg_front.sv =====
// Front end: order endpoints, pick the octant, seed the decision value.
module mlpg_front #(
   parameter int COORD_BITS = 12
) (
   mlpg_req_if.sink req_chan,
   input logic queue_full,
   output logic queue_push,
   output logic [mlpg_pkg::cmd_width(COORD_BITS)-1:0] queue_data
);
   import mlpg_pkg::*;

   localparam int C = COORD_BITS;
   localparam int DW = C + 1;
   localparam int PW = C + 3;

   typedef struct packed {
      logic step;
      logic [C-1:0] x1;
      logic [C-1:0] y1;
      logic [PW-1:0] seed;
      logic [PW-1:0] add_neg;
      logic [PW-1:0] add_pos;
      logic [DW-1:0] steps;
      octant_type oct;
      logic [COLOUR_BITS-1:0] colour;
   } cmd_type;

   logic signed [C-1:0] a1x, a1y, a2x, a2y;
   logic swap;
   logic signed [DW-1:0] dx, dy;
   logic signed [PW-1:0] dxp, dyp, ndy, numer, rounded;
   cmd_type cmd;

   assign req_chan.ready = !queue_full;
   assign queue_push = req_chan.valid && !queue_full;

   always_comb begin
      swap = (req_chan.start_x >= req_chan.end_x);
      a1x = swap ? req_chan.end_x : req_chan.start_x;
      a1y = swap ? req_chan.end_y : req_chan.start_y;
      a2x = swap ? req_chan.start_x : req_chan.end_x;
      a2y = swap ? req_chan.start_y : req_chan.end_y;
      dx = {a2x[C-1], a2x} - {a1x[C-1], a1x};
      dy = {a2y[C-1], a2y} - {a1y[C-1], a1y};
      dxp = {{2{dx[DW-1]}}, dx};
      dyp = {{2{dy[DW-1]}}, dy};
      ndy = -dyp;

      cmd.step = (req_chan.command == CMD_STEP);
      cmd.x1 = a1x;
      cmd.y1 = a1y;
      cmd.colour = req_chan.pen_colour;

      // Classify; zero-length lines fall through to a single pixel.
      priority if (dy > 0 && dyp <= dxp) begin
         cmd.oct = OCT_SHALLOW_RISE;
         numer = dxp - (dyp <<< 1);
         cmd.steps = dx;
         cmd.add_neg = dxp - dyp;
         cmd.add_pos = ndy;
      end else if (dy > 0) begin
         cmd.oct = OCT_STEEP_RISE;
         numer = (dxp <<< 1) - dyp;
         cmd.steps = dy;
         cmd.add_neg = dxp;
         cmd.add_pos = dxp - dyp;
      end else if (dx != 0 && ndy <= dxp) begin
         cmd.oct = OCT_SHALLOW_FALL;
         numer = -dxp - (dyp <<< 1);
         cmd.steps = dx;
         cmd.add_neg = ndy;
         cmd.add_pos = -(dxp + dyp);
      end else if (dy < 0) begin
         cmd.oct = OCT_STEEP_FALL;
         numer = -(dxp <<< 1) - dyp;
         cmd.steps = -dy;
         cmd.add_neg = -(dxp + dyp);
         cmd.add_pos = -dxp;
      end else begin
         cmd.oct = OCT_SHALLOW_RISE;
         numer = '0;
         cmd.steps = '0;
         cmd.add_neg = '0;
         cmd.add_pos = '0;
      end

      // Halve, truncating toward zero.
      rounded = numer + {{(PW-1){1'b0}}, numer[PW-1]};
      cmd.seed = rounded >>> 1;
      queue_data = cmd;
   end

endmodule

// ===== hdl/mlpg_cmd_queue.sv =====
// Two-entry queue between the front end and the stepping engine.
module mlpg_cmd_queue #(
   parameter int WIDTH = 89
) (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [WIDTH-1:0] push_data,
   input logic pop,
   output logic [WIDTH-1:0] head_data,
   output logic not_empty,
   output logic full
);
   logic [WIDTH-1:0] entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head_data = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/mlpg_back.sv =====
// Stepping engine: walk the line one pixel per transaction and register the response.
module mlpg_back #(
   parameter int COORD_BITS = 12
) (
   input logic clock,
   input logic reset,
   input logic queue_not_empty,
   input logic [mlpg_pkg::cmd_width(COORD_BITS)-1:0] queue_head,
   output logic queue_pop,
   input logic [mlpg_pkg::ORIGIN_BITS-1:0] origin_x,
   input logic [mlpg_pkg::ORIGIN_BITS-1:0] origin_y,
   mlpg_rsp_if.source rsp_chan
);
   import mlpg_pkg::*;

   localparam int C = COORD_BITS;
   localparam int CX = C + 1;
   localparam int DW = C + 1;
   localparam int PW = C + 3;
   localparam int SW = (C + 2 > SCREEN_BITS) ? C + 2 : SCREEN_BITS;

   typedef struct packed {
      logic step;
      logic [C-1:0] x1;
      logic [C-1:0] y1;
      logic [PW-1:0] seed;
      logic [PW-1:0] add_neg;
      logic [PW-1:0] add_pos;
      logic [DW-1:0] steps;
      octant_type oct;
      logic [COLOUR_BITS-1:0] colour;
   } cmd_type;

   cmd_type cmd;

   logic [CX-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [PW-1:0] dec_ff, dec_in, add_neg_ff, add_neg_in, add_pos_ff, add_pos_in;
   logic [DW-1:0] steps_ff, steps_in;
   octant_type oct_ff, oct_in;
   logic [COLOUR_BITS-1:0] colour_ff, colour_in;
   logic active_ff, active_in;

   logic rsp_valid_ff;
   logic [SCREEN_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [COLOUR_BITS-1:0] pcol_ff, pcol_in;
   logic pval_ff, pval_in, last_ff, last_in;

   logic p_neg, x_inc, y_inc, y_dec;
   logic [SW-1:0] sum_x, diff_y;

   assign cmd = cmd_type'(queue_head);
   assign queue_pop = queue_not_empty && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      p_neg = dec_ff[PW-1];
      x_inc = 1'b0;
      y_inc = 1'b0;
      y_dec = 1'b0;
      unique case (oct_ff)
         OCT_SHALLOW_RISE: begin
            x_inc = 1'b1;
            y_inc = p_neg;
         end
         OCT_STEEP_RISE: begin
            y_inc = 1'b1;
            x_inc = !p_neg;
         end
         OCT_SHALLOW_FALL: begin
            x_inc = 1'b1;
            y_dec = !p_neg;
         end
         OCT_STEEP_FALL: begin
            y_dec = 1'b1;
            x_inc = p_neg;
         end
         default: begin
            x_inc = 1'b0;
         end
      endcase

      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      dec_in = dec_ff;
      add_neg_in = add_neg_ff;
      add_pos_in = add_pos_ff;
      steps_in = steps_ff;
      oct_in = oct_ff;
      colour_in = colour_ff;
      active_in = active_ff;
      pval_in = 1'b0;
      last_in = 1'b0;

      if (!cmd.step) begin
         // Start: drop any line in progress, emit its first pixel now.
         cur_x_in = {cmd.x1[C-1], cmd.x1};
         cur_y_in = {cmd.y1[C-1], cmd.y1};
         dec_in = cmd.seed;
         add_neg_in = cmd.add_neg;
         add_pos_in = cmd.add_pos;
         steps_in = cmd.steps;
         oct_in = cmd.oct;
         colour_in = cmd.colour;
         active_in = (cmd.steps != '0);
         pval_in = 1'b1;
         last_in = (cmd.steps == '0);
      end else if (active_ff) begin
         cur_x_in = cur_x_ff + {{(CX-1){1'b0}}, x_inc};
         cur_y_in = cur_y_ff + {{(CX-1){y_dec}}, y_inc | y_dec};
         dec_in = dec_ff + (p_neg ? add_neg_ff : add_pos_ff);
         steps_in = steps_ff - {{(DW-1){1'b0}}, 1'b1};
         active_in = (steps_in != '0);
         pval_in = 1'b1;
         last_in = (steps_in == '0);
      end

      sum_x = {{(SW-ORIGIN_BITS){1'b0}}, origin_x} + {{(SW-CX){cur_x_in[CX-1]}}, cur_x_in};
      diff_y = {{(SW-ORIGIN_BITS){1'b0}}, origin_y} - {{(SW-CX){cur_y_in[CX-1]}}, cur_y_in};
      px_in = pval_in ? sum_x[SCREEN_BITS-1:0] : '0;
      py_in = pval_in ? diff_y[SCREEN_BITS-1:0] : '0;
      pcol_in = pval_in ? colour_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (queue_pop) begin
            active_ff <= active_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         dec_ff <= dec_in;
         add_neg_ff <= add_neg_in;
         add_pos_ff <= add_pos_in;
         steps_ff <= steps_in;
         oct_ff <= oct_in;
         colour_ff <= colour_in;
         px_ff <= px_in;
         py_ff <= py_in;
         pcol_ff <= pcol_in;
         pval_ff <= pval_in;
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_x = px_ff;
   assign rsp_chan.pixel_y = py_ff;
   assign rsp_chan.pixel_colour = pcol_ff;
   assign rsp_chan.pixel_valid = pval_ff;
   assign rsp_chan.last_pixel = last_ff;

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> pval_ff)
      else $error("last_pixel set on a response without a pixel");

   a_idle_step_blank: assert property (@(posedge clock) disable iff (reset)
      queue_pop && cmd.step && !active_ff |=> !pval_ff && px_ff == '0 && py_ff == '0)
      else $error("step with no active line produced a pixel");

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> steps_ff != '0)
      else $error("active line with no steps left");

   a_single_pixel_line: assert property (@(posedge clock) disable iff (reset)
      queue_pop && !cmd.step && cmd.steps == '0 |=> !active_ff && last_ff && pval_ff)
      else $error("zero-length line not closed after its only pixel");

endmodule

// ===== hdl/midpoint_line_pixel_generator_core.sv =====
// Top level of the midpoint line pixel generator: origin registers, front end, queue, engine.
//
// Usage:
//   req_chan carries commands. A start transaction (command 0) takes two endpoints in
//   centered math coordinates (y upward) and a pen colour and yields the first pixel at
//   once. Each step transaction (command 1) yields the next pixel of the active line, or a
//   response with pixel_valid 0 and all fields 0 when no line is active.
//   rsp_chan returns exactly one transaction per request, in request order, with screen
//   coordinates origin_x + x and origin_y - y wrapped to 14 bits and last_pixel on the
//   final pixel. A start during an active line drops the old line.
//   csr_we/csr_index/csr_wdata write origin_x (index 0) and origin_y (index 1); write
//   them only while no transaction is in flight.
// Timing:
//   From request acceptance to response valid, the command lands in the two-entry queue
//   and is then popped into the engine's response register.
//   Throughput is one transaction per cycle when rsp_chan does not stall.
// Reset:
//   Synchronous, active high; clears the queue, the active line and both origins.
// Backpressure:
//   When rsp_chan stalls, hold the response; the queue absorbs up to two more requests
//   before req_chan.ready drops.
module midpoint_line_pixel_generator_core #(
   parameter int COORD_BITS = 12
) (
   input logic clock,
   input logic reset,
   mlpg_req_if.sink req_chan,
   mlpg_rsp_if.source rsp_chan,
   input logic csr_we,
   input logic [mlpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [mlpg_pkg::ORIGIN_BITS-1:0] csr_wdata
);
   import mlpg_pkg::*;

   localparam int CMD_W = cmd_width(COORD_BITS);

   // Origin registers: the engine reads them as each pixel is formed.
   logic [ORIGIN_BITS-1:0] origin_x_ff, origin_x_in;
   logic [ORIGIN_BITS-1:0] origin_y_ff, origin_y_in;

   logic queue_push, queue_pop, queue_full, queue_not_empty;
   logic [CMD_W-1:0] push_data, head_data;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X: origin_x_in = csr_wdata;
            REG_ORIGIN_Y: origin_y_in = csr_wdata;
            default: origin_x_in = origin_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
      end
   end

   // Classify each request as it arrives.
   mlpg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_data)
   );

   // Decouple classification from stepping.
   mlpg_cmd_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .pop       (queue_pop),
      .head_data (head_data),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // Advance the line and register one response per command.
   mlpg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (head_data),
      .queue_pop       (queue_pop),
      .origin_x        (origin_x_ff),
      .origin_y        (origin_y_ff),
      .rsp_chan        (rsp_chan)
   );

endmodule
